// ===== src/eav_pkg.sv =====
`timescale 1ns / 1ps

package eav_pkg;

  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_RBRACKET = 8'h5d;
  localparam logic [7:0] CH_COLON    = 8'h3a;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;

  localparam int unsigned PFX_LEN = 4;
  localparam logic [7:0] TCP_PREFIX [PFX_LEN] = '{8'h74, 8'h63, 8'h70, 8'h2f};

  localparam logic [2:0] PFX_STRIPPED = 3'd4;
  localparam logic [2:0] PFX_NONE     = 3'd5;

  localparam logic [15:0] PORT_MAX = 16'hffff;

  typedef enum logic [1:0] {
    PH_INSIDE = 2'd0,
    PH_CLOSED = 2'd1,
    PH_PORT   = 2'd2
  } eav_phase_t;

  typedef struct packed {
    logic [15:0] value;
    logic        overflow;
    logic        nondigit;
    logic        empty;
  } eav_port_t;

  typedef struct packed {
    logic [2:0] prefix;
    logic       bracket_form;
    eav_phase_t bracket_phase;
    eav_port_t  port;
    logic       colon_seen;
    logic       colon_at_start;
    logic       failed;
  } eav_state_t;

  localparam eav_port_t PORT_CLEAR = '{
    value: 16'd0, overflow: 1'b0, nondigit: 1'b0, empty: 1'b1
  };

  localparam eav_state_t STATE_CLEAR = '{
    prefix: 3'd0, bracket_form: 1'b0, bracket_phase: PH_INSIDE, port: PORT_CLEAR,
    colon_seen: 1'b0, colon_at_start: 1'b0, failed: 1'b0
  };

endpackage

// ===== src/eav_step.sv =====
`timescale 1ns / 1ps

module eav_step #(
  parameter int unsigned MAX_LEN = 256,
  parameter int unsigned CNT_W   = $clog2(MAX_LEN + 2)
) (
  input  logic [CNT_W-1:0]   count_i,
  input  eav_pkg::eav_state_t state_i,
  input  logic               has_char,
  input  logic [7:0]         char_code,
  output logic [CNT_W-1:0]   count_o,
  output eav_pkg::eav_state_t state_o,
  output logic               dialable_o
);
  import eav_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] POS_PFX0 = CNT_W'(PFX_LEN);
  localparam logic [CNT_W-1:0] POS_PFX1 = CNT_W'(PFX_LEN + 1);

  function automatic eav_port_t port_take(eav_port_t p, logic [7:0] c);
    eav_port_t  r;
    logic [19:0] v;
    r = p;
    v = 20'(p.value) * 20'd10 + 20'(c - CH_ZERO);
    r.empty = 1'b0;
    if (c < CH_ZERO || c > CH_NINE) begin
      r.nondigit = 1'b1;
    end else if (!p.overflow) begin
      if (v > 20'(PORT_MAX)) begin
        r.overflow = 1'b1;
      end else begin
        r.value = v[15:0];
      end
    end
    return r;
  endfunction

  eav_state_t       st;
  logic [CNT_W-1:0] cnt;
  logic             take;
  logic             sidx0;
  logic             sidx1;
  logic             form_ok;

  always_comb begin
    st    = state_i;
    cnt   = count_i;
    take  = 1'b0;
    sidx0 = 1'b0;
    sidx1 = 1'b0;
    if (has_char && count_i <= CNT_MAX) begin
      if (count_i == CNT_MAX) begin
        cnt = CNT_SAT;
      end else begin
        cnt = count_i + CNT_W'(1);
        if (!st.failed) begin
          take = 1'b1;
          if (st.prefix < PFX_STRIPPED) begin
            if (count_i == CNT_W'(st.prefix) && char_code == TCP_PREFIX[st.prefix[1:0]]) begin
              st.prefix = st.prefix + 3'd1;
              take      = 1'b0;
            end else begin
              st.prefix = PFX_NONE;
            end
          end
        end
      end
    end
    if (take) begin
      sidx0 = (st.prefix == PFX_STRIPPED) ? (count_i == POS_PFX0) : (count_i == '0);
      sidx1 = (st.prefix == PFX_STRIPPED) ? (count_i == POS_PFX1) : (count_i == CNT_W'(1));
      if (sidx0 && char_code == CH_LBRACKET) begin
        st.bracket_form  = 1'b1;
        st.bracket_phase = PH_INSIDE;
      end else if (st.bracket_form) begin
        case (st.bracket_phase)
          PH_INSIDE: begin
            if (char_code == CH_RBRACKET) begin
              if (sidx1) begin
                st.failed = 1'b1;
              end else begin
                st.bracket_phase = PH_CLOSED;
              end
            end
          end
          PH_CLOSED: begin
            if (char_code == CH_COLON) begin
              st.bracket_phase = PH_PORT;
              st.port          = PORT_CLEAR;
            end else begin
              st.failed = 1'b1;
            end
          end
          default: begin
            st.port = port_take(st.port, char_code);
          end
        endcase
      end else if (char_code == CH_COLON) begin
        st.colon_seen     = 1'b1;
        st.colon_at_start = sidx0;
        st.port           = PORT_CLEAR;
      end else begin
        st.port = port_take(st.port, char_code);
      end
    end
  end

  always_comb begin
    form_ok = st.bracket_form ? (st.bracket_phase == PH_PORT)
                              : (st.colon_seen && !st.colon_at_start);
    dialable_o = (cnt != '0) && (cnt <= CNT_MAX) && !st.failed && form_ok &&
                 !st.port.empty && !st.port.nondigit && !st.port.overflow &&
                 (st.port.value != 16'd0);
  end

  assign count_o = cnt;
  assign state_o = st;

endmodule

// ===== src/endpoint_address_validator.sv =====
`timescale 1ns / 1ps

// Checks an endpoint string such as "tcp/host:7447" or "[::1]:80" that arrives
// at most one character per request, and returns one dialable verdict on the request
// that carries last. A request is taken in every cycle while the result register
// is free or being emptied, and a string's verdict is registered and appears in the
// cycle after its last request is taken; the only limit is the single result
// register, which stalls input while a verdict waits and out_stall is high.
// Strings longer than MAX_LEN characters are rejected.
module endpoint_address_validator #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_has_char,
  input  logic [7:0] in_char_code,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_dialable
);
  import eav_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 2);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  eav_state_t       state_r;
  eav_state_t       state_nxt;
  logic             out_valid_r;
  logic             out_dialable_r;
  logic             verdict;
  logic             in_acc;
  logic             out_acc;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  eav_step #(
    .MAX_LEN (MAX_LEN),
    .CNT_W   (CNT_W)
  ) u_step (
    .count_i    (count_r),
    .state_i    (state_r),
    .has_char   (in_has_char),
    .char_code  (in_char_code),
    .count_o    (count_nxt),
    .state_o    (state_nxt),
    .dialable_o (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      state_r     <= STATE_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_last) begin
          count_r <= '0;
          state_r <= STATE_CLEAR;
        end else begin
          count_r <= count_nxt;
          state_r <= state_nxt;
        end
      end
      if (in_acc && in_last) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_last) begin
      out_dialable_r <= verdict;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dialable = out_dialable_r;

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> out_valid_r)
    else $error("last request did not produce a result");

  a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> count_r == '0 && state_r == STATE_CLEAR)
    else $error("state not cleared after verdict");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_LEN + 1))
    else $error("character count beyond saturation");

  a_empty_request_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_last && !in_has_char |=> $stable(count_r) && $stable(state_r))
    else $error("request without character changed state");

  a_phase_plain_form: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.bracket_form |-> state_r.bracket_phase == PH_INSIDE)
    else $error("bracket phase moved outside bracketed form");
`endif

endmodule
